>>> src/bae_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap allocation engine package
// Shared word width, request and status codes, and the per-word statistics
// bundle passed from the word unit to the sequencer.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int WORD_BITS = 64;

  typedef logic [WORD_BITS-1:0] map_word_t;

  // Request codes.
  localparam logic [1:0] ACT_FILL    = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_FIND    = 2'd2;
  localparam logic [1:0] ACT_RECOUNT = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Per-word statistics from the shared word unit.
  typedef struct packed {
    logic [6:0] ones;      // popcount of the word
    logic [5:0] zero_pos;  // lowest clear bit, valid when has_zero
    logic       has_zero;
    logic       is_full;
    logic       is_empty;
  } word_stats_t;

endpackage

>>> src/bae_map_ram.sv
// ----------------------------------------------------------------------------
// Bitmap word memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bae_map_ram
  import bae_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  map_word_t       wdata,
  input  logic [AW-1:0]   raddr,
  output map_word_t       rdata
);

  map_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bae_word_unit.sv
// ----------------------------------------------------------------------------
// Bitmap word unit
// Shared datapath for one 64-bit word: masked set or clear of bits lo..hi,
// popcount, lowest clear bit and full/empty tests.
// ----------------------------------------------------------------------------
module bae_word_unit
  import bae_pkg::*;
(
  input  map_word_t   word,
  input  logic [5:0]  lo,
  input  logic [5:0]  hi,
  input  logic        fill,
  output map_word_t   wdata,
  output word_stats_t stats
);

  map_word_t mask;

  // Popcount adder tree, one level per doubling of the group size.
  logic [1:0] sum2  [32];
  logic [2:0] sum4  [16];
  logic [3:0] sum8  [8];
  logic [4:0] sum16 [4];
  logic [5:0] sum32 [2];

  // Bits lo..hi inclusive; the user must keep lo at or below hi, which the unit itself does not enforce.
  assign mask  = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));
  assign wdata = fill ? (word | mask) : (word & ~mask);

  always_comb begin
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 32; i++) begin
      sum2[i] = {1'b0, word[2*i]} + {1'b0, word[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      sum4[i] = {1'b0, sum2[2*i]} + {1'b0, sum2[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      sum8[i] = {1'b0, sum4[2*i]} + {1'b0, sum4[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      sum16[i] = {1'b0, sum8[2*i]} + {1'b0, sum8[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      sum32[i] = {1'b0, sum16[2*i]} + {1'b0, sum16[2*i+1]};
    end
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = 6'(i);
      end
    end
    stats.ones     = {1'b0, sum32[0]} + {1'b0, sum32[1]};
    stats.zero_pos = pos;
    stats.has_zero = ~&word;
    stats.is_full  = &word;
    stats.is_empty = ~|word;
  end

endmodule

>>> src/bitmap_allocation_engine_unit.sv
// ----------------------------------------------------------------------------
// Bitmap allocation engine
// Allocation bitmap of 64-bit words with range fill, bit read, find-first-free
// and popcount recount, walked one word at a time by a small sequencer.
// ----------------------------------------------------------------------------
// After reset the block clears its bitmap memory one word per cycle and
// holds in_stall high meanwhile; configuration writes are taken at any
// time. Each request then walks the memory through a single read port and a
// single shared word unit. A fill first rewrites every touched word by
// read-modify-write, a read step and then a write step per word. Every
// request, fill included, then scans all words in use once, at one word per
// cycle, to collect the free search, the popcount, the bit read and the full
// and empty flags. A result that finds the output register still occupied
// waits until it is free. One request is in flight at a time, but the next
// beat is taken while a finished result still waits in the output register.
// The words_in_use register lies at byte address 0 of the configuration
// port; its value is clipped to MAX_WORDS where it is used, and the used
// count only changes on a recount.
// ----------------------------------------------------------------------------
module bitmap_allocation_engine_unit
  import bae_pkg::*;
#(
  parameter int MAX_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [11:0] start_index,
  input  logic [12:0] range_len,
  input  logic        fill_value,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        bit_value,
  output logic [11:0] found_index,
  output logic [12:0] used_count,
  output logic        all_full,
  output logic        all_empty
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [12:0] MAX_WORDS_W = 13'(MAX_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WORDS - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_FILL_RD = 3'd2;
  localparam logic [2:0] S_FILL_WR = 3'd3;
  localparam logic [2:0] S_SCAN    = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]    state;
  logic [6:0]    words_in_use;
  logic [12:0]   used_tally;
  logic [AW-1:0] clr_addr;

  // Request held for the whole walk.
  logic [1:0]  act;
  logic [11:0] start_reg;
  logic        fill_reg;
  logic [1:0]  pre_status;
  logic [6:0]  first_word;
  logic [6:0]  last_word;
  logic [5:0]  first_lo;
  logic [5:0]  last_hi;

  // Walk counters and scan accumulators.
  logic [6:0]  fill_word;
  logic [6:0]  scan_addr;
  logic        rd_pend;
  logic [6:0]  rd_idx;
  logic [12:0] acc_sum;
  logic        acc_full;
  logic        acc_empty;
  logic        acc_found;
  logic [11:0] acc_index;
  logic        acc_bit;

  // Memory and word unit hookup.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  map_word_t     ram_wdata;
  map_word_t     ram_rdata;
  map_word_t     unit_wdata;
  word_stats_t   unit_stats;
  logic [5:0]    unit_lo;
  logic [5:0]    unit_hi;

  // Request decode.
  logic [6:0]  live_words;
  logic [12:0] size_bits;
  logic [13:0] range_end;
  logic [13:0] clip_end;
  logic [13:0] last_bit;
  logic        range_over;
  logic        do_fill;
  logic        in_accept;
  logic        out_free;
  logic [1:0]  res_status;

  // The register may exceed the memory depth; the excess is ignored.
  assign live_words = ({6'd0, words_in_use} > MAX_WORDS_W) ? 7'(MAX_WORDS) : words_in_use;
  assign size_bits  = {live_words, 6'd0};

  assign range_end  = {2'd0, start_index} + {1'b0, range_len};
  assign range_over = range_end > {1'b0, size_bits};
  assign clip_end   = range_over ? {1'b0, size_bits} : range_end;
  assign last_bit   = clip_end - 14'd1;
  assign do_fill    = (range_len != '0) && ({2'd0, start_index} < clip_end);

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Configuration port: one register, write with the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, words_in_use} : 32'd0;

  // Partial words only at the two ends of the range.
  assign unit_lo = (fill_word == first_word) ? first_lo : 6'd0;
  assign unit_hi = (fill_word == last_word) ? last_hi : 6'd63;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(fill_word);
    ram_wdata = unit_wdata;
    ram_raddr = AW'(scan_addr);
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_FILL_RD: begin
        ram_raddr = AW'(fill_word);
      end
      S_FILL_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (act)
      ACT_FILL:    res_status = pre_status;
      ACT_READ:    res_status = pre_status;
      ACT_FIND:    res_status = acc_found ? ST_OK : ST_NO_FREE;
      ACT_RECOUNT: res_status = ST_OK;
      default:     res_status = ST_OK;
    endcase
  end

  bae_map_ram #(
    .DEPTH (MAX_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bae_word_unit u_word (
    .word  (ram_rdata),
    .lo    (unit_lo),
    .hi    (unit_hi),
    .fill  (fill_reg),
    .wdata (unit_wdata),
    .stats (unit_stats)
  );

  // Sequencer and register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      words_in_use <= 7'd64;
      used_tally   <= '0;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
        words_in_use <= pwdata[6:0];
      end

      // In the done step the new result takes over from a leaving beat.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            act        <= action;
            start_reg  <= start_index;
            fill_reg   <= fill_value;
            first_word <= {1'b0, start_index[11:6]};
            last_word  <= last_bit[12:6];
            first_lo   <= start_index[5:0];
            last_hi    <= last_bit[5:0];
            fill_word  <= {1'b0, start_index[11:6]};
            scan_addr  <= '0;
            rd_pend    <= 1'b0;
            acc_sum    <= '0;
            acc_full   <= 1'b1;
            acc_empty  <= 1'b1;
            acc_found  <= 1'b0;
            acc_index  <= '0;
            acc_bit    <= 1'b0;
            if (action == ACT_READ) begin
              pre_status <= ({1'b0, start_index} >= size_bits) ? ST_RANGE : ST_OK;
            end else begin
              pre_status <= ((range_len != '0) && range_over) ? ST_RANGE : ST_OK;
            end
            if ((action == ACT_FILL) && do_fill) begin
              state <= S_FILL_RD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_FILL_RD: begin
          state <= S_FILL_WR;
        end
        S_FILL_WR: begin
          if (fill_word == last_word) begin
            state <= S_SCAN;
          end else begin
            fill_word <= fill_word + 7'd1;
            state     <= S_FILL_RD;
          end
        end
        S_SCAN: begin
          // The address runs ahead of the registered read data, which arrives in the next cycle.
          if (scan_addr < live_words) begin
            scan_addr <= scan_addr + 7'd1;
            rd_idx    <= scan_addr;
            rd_pend   <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            acc_sum   <= acc_sum + {6'd0, unit_stats.ones};
            acc_full  <= acc_full & unit_stats.is_full;
            acc_empty <= acc_empty & unit_stats.is_empty;
            if (!acc_found && unit_stats.has_zero) begin
              acc_found <= 1'b1;
              acc_index <= {rd_idx[5:0], unit_stats.zero_pos};
            end
            if (rd_idx == {1'b0, start_reg[11:6]}) begin
              acc_bit <= ram_rdata[start_reg[5:0]];
            end
          end
          if ((scan_addr == live_words) && !rd_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            bit_value   <= (act == ACT_READ) ? acc_bit : 1'b0;
            found_index <= ((act == ACT_FIND) && acc_found) ? acc_index : 12'd0;
            used_count  <= (act == ACT_RECOUNT) ? acc_sum : used_tally;
            all_full    <= acc_full;
            all_empty   <= acc_empty;
            if (act == ACT_RECOUNT) begin
              used_tally <= acc_sum;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A word in use cannot be both all ones and all zeros.
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && acc_full && acc_empty) |-> (live_words == 7'd0))
    else $error("full and empty both set with words in use");

  // The memory is only written by the clear pass and the fill write step.
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_SCAN || state == S_DONE) |-> !ram_we)
    else $error("bitmap written outside clear or fill");

  // A result beat only appears when a request has finished its walk.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result beat without a finished request");

  // The scan only consumes words inside the configured size.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && rd_pend) |-> (rd_idx < live_words))
    else $error("scan read a word beyond the words in use");

endmodule

>>> tb/bitmap_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap allocation engine scoreboard
// Keeps a bit-accurate copy of the allocation bitmap, the used tally and the
// words_in_use setting, predicts the result of every accepted request and
// compares each returned result against the oldest prediction.
// ----------------------------------------------------------------------------
package bitmap_tb_pkg;
  import bae_pkg::*;

  localparam int MAP_WORDS = 64;
  localparam int TALLY_MAX = 8191;

  typedef struct packed {
    logic [1:0]  status;
    logic        bit_value;
    logic [11:0] found_index;
    logic [12:0] used_count;
    logic        all_full;
    logic        all_empty;
  } alloc_reply_t;

  class bitmap_scoreboard;
    map_word_t    bitmap [MAP_WORDS];
    logic [12:0]  tally;
    logic [6:0]   words_reg;
    alloc_reply_t replies_due [$];
    int           mismatches;
    int           replies_seen;

    function new();
      foreach (bitmap[w]) bitmap[w] = '0;
      tally = '0;
      words_reg = 7'd64;
      mismatches = 0;
      replies_seen = 0;
    endfunction

    function void set_words_in_use(logic [31:0] value);
      words_reg = value[6:0];
    endfunction

    // The register saturates at the number of words the block holds.
    function int live_words();
      return (words_reg > MAP_WORDS) ? MAP_WORDS : int'(words_reg);
    endfunction

    function int first_free();
      int size_bits;
      size_bits = live_words() * 64;
      for (int b = 0; b < size_bits; b++)
        if (!bitmap[b / 64][b % 64]) return b;
      return -1;
    endfunction

    function alloc_reply_t predict_request(logic [1:0] act, logic [11:0] start,
                                           logic [12:0] count, logic value);
      alloc_reply_t r;
      int words;
      int size_bits;
      int stop_bit;
      int ones;
      r = '0;
      words = live_words();
      size_bits = words * 64;
      case (act)
        ACT_FILL: begin
          if (count != 0) begin
            stop_bit = int'(start) + int'(count);
            if (stop_bit > size_bits) begin
              r.status = ST_RANGE;
              stop_bit = size_bits;
            end
            for (int b = int'(start); b < stop_bit; b++) bitmap[b / 64][b % 64] = value;
          end
        end
        ACT_READ: begin
          if (int'(start) >= size_bits) r.status = ST_RANGE;
          else r.bit_value = bitmap[start[11:6]][start[5:0]];
        end
        ACT_FIND: begin
          r.status = ST_NO_FREE;
          for (int b = 0; b < size_bits && r.status == ST_NO_FREE; b++) begin
            if (!bitmap[b / 64][b % 64]) begin
              r.status = ST_OK;
              r.found_index = 12'(b);
            end
          end
        end
        ACT_RECOUNT: begin
          ones = 0;
          for (int w = 0; w < words; w++) ones += $countones(bitmap[w]);
          tally = (ones > TALLY_MAX) ? 13'(TALLY_MAX) : 13'(ones);
        end
      endcase
      // With no words in use both flags hold.
      r.all_full = 1'b1;
      r.all_empty = 1'b1;
      for (int w = 0; w < words; w++) begin
        if (bitmap[w] != '1) r.all_full = 1'b0;
        if (bitmap[w] != '0) r.all_empty = 1'b0;
      end
      r.used_count = tally;
      return r;
    endfunction

    function void note_request(logic [1:0] act, logic [11:0] start, logic [12:0] count,
                               logic value);
      replies_due.push_back(predict_request(act, start, count, value));
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                  replies_seen, name, got, want));
    endtask

    task check_reply(logic [1:0] st, logic bv, logic [11:0] fi, logic [12:0] uc,
                     logic af, logic ae);
      alloc_reply_t want;
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                  replies_seen));
        return;
      end
      want = replies_due.pop_front();
      compare_field("status", 32'(st), 32'(want.status));
      compare_field("bit_value", 32'(bv), 32'(want.bit_value));
      compare_field("found_index", 32'(fi), 32'(want.found_index));
      compare_field("used_count", 32'(uc), 32'(want.used_count));
      compare_field("all_full", 32'(af), 32'(want.all_full));
      compare_field("all_empty", 32'(ae), 32'(want.all_empty));
    endtask
  endclass

endpackage

>>> tb/tb_bitmap_allocation_engine_unit.sv
// ----------------------------------------------------------------------------
// Bitmap allocation engine testbench
// Drives fill, read, find and recount requests through the valid/stall
// request channel, changes words_in_use over the APB port between phases, and
// checks every result beat against the scoreboard's bitmap prediction. The
// sender and the receiver idle at random, and the receiver twice holds off for
// a long stretch so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_bitmap_allocation_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bae_pkg::*;
  import bitmap_tb_pkg::*;

  localparam int REG_WORDS_IN_USE = 0;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 175;
  // The watchdog limit lies well above the walk of the slowest request, which
  // rewrites all 64 words and then scans them, plus the long hold-off.
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_FILL;
  logic [11:0] start_index = '0;
  logic [12:0] range_len = '0;
  logic        fill_value = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        bit_value;
  logic [11:0] found_index;
  logic [12:0] used_count;
  logic        all_full;
  logic        all_empty;

  bitmap_scoreboard sb = new();

  // Idling percentages for the current phase, and the request for a long
  // receiver hold-off that the receiver process picks up at its next edge.
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_pending = 1'b0;
  int   requests_sent = 0;
  int   idle_cycles = 0;

  // The word counts visited by the random phases; 0, 1, 64 and the
  // saturating 127 are the extremes of the register.
  int phase_words [PHASE_COUNT] = '{3, 1, 127, 0, 17, 2, 64, 40};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_allocation_engine_unit #(.MAX_WORDS(MAP_WORDS)) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .start_index(start_index),
    .range_len(range_len),
    .fill_value(fill_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .bit_value(bit_value),
    .found_index(found_index),
    .used_count(used_count),
    .all_full(all_full),
    .all_empty(all_empty)
  );

  // Monitor. All block inputs change by nonblocking assignment at the edge, so
  // the values read here are the ones the block saw at this edge. A request
  // beat is predicted when taken; a result beat is checked when taken. The
  // watchdog counts edges at which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(action, start_index, range_len, fill_value);
      if (out_valid && !out_stall)
        sb.check_reply(status, bit_value, found_index, used_count, all_full, all_empty);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Receiver. It stalls at random at the phase's rate, or, once asked, holds
  // the result channel off in one unbroken stretch, whose length HOLD_CYCLES
  // sets, while the sender keeps offering beats.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offers one request beat after a random idle gap and returns at the edge
  // where the block takes it. Valid stays high into the next call, so back to
  // back beats never drop valid in between.
  task automatic offer_request(logic [1:0] act, logic [11:0] start, logic [12:0] count,
                               logic value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    start_index <= start;
    range_len <= count;
    fill_value <= value;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Random request. Fills, mostly short and mostly inside the live range,
  // often allocate from the lowest free bit so that the map fills up; reads
  // mostly land inside the live range. Fields an action ignores carry noise.
  task automatic offer_random_request();
    int size_bits;
    int pick;
    int free_bit;
    logic [1:0]  act;
    logic [11:0] start;
    logic [12:0] count;
    logic        value;
    size_bits = sb.live_words() * 64;
    pick = $urandom_range(99);
    start = 12'($urandom_range(4095));
    count = 13'($urandom_range(4096));
    value = 1'($urandom_range(1));
    if (pick < 40) begin
      act = ACT_FILL;
      if (size_bits > 0 && $urandom_range(9) < 8) start = 12'($urandom_range(size_bits - 1));
      free_bit = sb.first_free();
      if (value && free_bit >= 0 && $urandom_range(1) == 1) start = 12'(free_bit);
      pick = $urandom_range(99);
      if (pick < 6) count = '0;
      else if (pick < 76) count = 13'($urandom_range(64, 1));
      else if (pick < 92) count = 13'($urandom_range(300, 65));
      else count = 13'($urandom_range(4096, 301));
    end else if (pick < 65) begin
      act = ACT_READ;
      if (size_bits > 0 && $urandom_range(99) < 85) start = 12'($urandom_range(size_bits - 1));
    end else if (pick < 85) begin
      act = ACT_FIND;
    end else begin
      act = ACT_RECOUNT;
    end
    offer_request(act, start, count, value);
  endtask

  // Drops valid and waits until every request taken so far has returned its
  // result, then lets the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.replies_seen < requests_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup edge, then access until pready. The scoreboard takes the
  // new value at the edge where the block writes it.
  task automatic write_register(int index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(index * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_WORDS_IN_USE) sb.set_words_in_use(value);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset setting of 64 words. The block clears its
    // memory first and stalls the first beat until it is done.
    offer_request(ACT_FIND, 12'd0, 13'd0, 1'b0);
    offer_request(ACT_RECOUNT, 12'd0, 13'd0, 1'b0);
    // Fill the whole map, then see the search fail and the tally at maximum.
    offer_request(ACT_FILL, 12'd0, 13'd4096, 1'b1);
    offer_request(ACT_FIND, 12'd0, 13'd0, 1'b0);
    offer_request(ACT_RECOUNT, 12'd0, 13'd0, 1'b0);
    offer_request(ACT_READ, 12'd4095, 13'd0, 1'b0);
    // A fill running past the end is clipped to the last bit.
    offer_request(ACT_FILL, 12'd4095, 13'd4096, 1'b0);
    offer_request(ACT_FIND, 12'd0, 13'd0, 1'b0);
    // An empty fill writes nothing.
    offer_request(ACT_FILL, 12'd5, 13'd0, 1'b1);
    // Partial words at both ends with a whole word between them.
    offer_request(ACT_FILL, 12'd3, 13'd130, 1'b0);
    offer_request(ACT_READ, 12'd3, 13'd0, 1'b0);
    offer_request(ACT_READ, 12'd2, 13'd0, 1'b0);
    offer_request(ACT_FIND, 12'd0, 13'd0, 1'b0);
    offer_request(ACT_FILL, 12'd0, 13'd4096, 1'b0);
    // Two bits straddling a word boundary.
    offer_request(ACT_FILL, 12'd63, 13'd2, 1'b1);
    offer_request(ACT_READ, 12'd64, 13'd0, 1'b0);
    offer_request(ACT_RECOUNT, 12'd0, 13'd0, 1'b0);

    // No words in use: reads and nonzero fills are out of range, the search
    // finds nothing, and both flags are set.
    wait_idle();
    write_register(REG_WORDS_IN_USE, 32'd0);
    offer_request(ACT_FILL, 12'd0, 13'd5, 1'b1);
    offer_request(ACT_FILL, 12'd0, 13'd0, 1'b1);
    offer_request(ACT_READ, 12'd0, 13'd0, 1'b0);
    offer_request(ACT_FIND, 12'd0, 13'd0, 1'b0);
    offer_request(ACT_RECOUNT, 12'd0, 13'd0, 1'b0);

    // A register value above the word count saturates to 64 words.
    wait_idle();
    write_register(REG_WORDS_IN_USE, 32'd127);
    offer_request(ACT_READ, 12'd4095, 13'd0, 1'b0);

    // One word: bits beyond it are out of range, a fill across the end is
    // clipped, and a fill starting past the end writes nothing.
    wait_idle();
    write_register(REG_WORDS_IN_USE, 32'd1);
    offer_request(ACT_READ, 12'd64, 13'd0, 1'b0);
    offer_request(ACT_FILL, 12'd60, 13'd10, 1'b1);
    offer_request(ACT_FILL, 12'd100, 13'd5, 1'b1);
    offer_request(ACT_FIND, 12'd0, 13'd0, 1'b0);

    // Random phases, each at its own word count and idling pattern. The
    // first and the 64-word phase also carry the long receiver hold-off.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      write_register(REG_WORDS_IN_USE, 32'(phase_words[p]));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct = 20;
          recv_stall_pct = 20;
        end
      endcase
      if (p == 0 || p == 6) hold_pending = 1'b1;
      repeat (PHASE_ITEMS) offer_random_request();
    end

    // Drain, then give the block time to show any stray result beat.
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/bae_pkg.sv
src/bae_map_ram.sv
src/bae_word_unit.sv
src/bitmap_allocation_engine_unit.sv
tb/bitmap_scoreboard_pkg.sv
tb/tb_bitmap_allocation_engine_unit.sv
